>>> src/tsgc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsgc_pkg
// Shared types and constants of the touch swipe gesture classifier.
// ----------------------------------------------------------------------------
package tsgc_pkg;

  localparam int unsigned FINGERS = 10;
  localparam int unsigned CNT_W   = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
  localparam logic [15:0] THR_RESET    = 16'h2000;

  localparam logic [1:0] MODE_MOVE    = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_OTHER   = 2'd3;

  localparam logic [1:0] KIND_PASS      = 2'd0;
  localparam logic [1:0] KIND_KEY       = 2'd1;
  localparam logic [1:0] KIND_TOUCH_TAP = 2'd2;
  localparam logic [1:0] KIND_MOUSE_TAP = 2'd3;

  localparam logic [7:0] KEY_NONE  = 8'h00;
  localparam logic [7:0] KEY_LEFT  = 8'h25;
  localparam logic [7:0] KEY_RIGHT = 8'h27;
  localparam logic [7:0] KEY_UP    = 8'h26;
  localparam logic [7:0] KEY_DOWN  = 8'h28;
  localparam logic [7:0] KEY_ESC   = 8'h1b;

  typedef logic signed [16:0] delta_t;

  typedef struct packed {
    delta_t dx0;
    delta_t dy0;
    delta_t dx1;
    delta_t dy1;
    delta_t dx2;
    delta_t dy2;
  } disp_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] key;
  } verdict_t;

endpackage
`default_nettype wire

>>> src/tsgc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsgc_in_if
// Touch event channel: valid/ready handshake with the event word.
// ----------------------------------------------------------------------------
interface tsgc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] finger_id;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  modport source (output valid, output mode, output finger_id, output pos_x,
                  output pos_y, input ready);
  modport sink (input valid, input mode, input finger_id, input pos_x,
                input pos_y, output ready);
endinterface
`default_nettype wire

>>> src/tsgc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsgc_out_if
// Result channel: valid/ready handshake with the classified event word.
// ----------------------------------------------------------------------------
interface tsgc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_type;
  logic [7:0]  key_code;
  logic [15:0] out_finger;
  logic [15:0] out_x;
  logic [15:0] out_y;

  modport source (output valid, output out_type, output key_code,
                  output out_finger, output out_x, output out_y, input ready);
  modport sink (input valid, input out_type, input key_code,
                input out_finger, input out_x, input out_y, output ready);
endinterface
`default_nettype wire

>>> src/tsgc_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsgc_classify
// Gesture decision from the slot displacements, threshold and touch count.
// ----------------------------------------------------------------------------
module tsgc_classify (
  input  tsgc_pkg::disp_t      disp,
  input  logic [15:0]          threshold,
  input  logic [3:0]           gesture_cnt,
  output tsgc_pkg::verdict_t   verdict
);
  import tsgc_pkg::*;

  logic signed [17:0] t_pos;
  logic signed [17:0] t_neg;
  logic signed [17:0] x0, y0, x1, y1, x2, y2;
  logic in_x0, in_y0, in_x1, in_x2;
  logic all_down, all_up;

  assign t_pos = $signed({2'b00, threshold});
  assign t_neg = -t_pos;
  assign x0 = 18'(disp.dx0);
  assign y0 = 18'(disp.dy0);
  assign x1 = 18'(disp.dx1);
  assign y1 = 18'(disp.dy1);
  assign x2 = 18'(disp.dx2);
  assign y2 = 18'(disp.dy2);

  assign in_x0 = (x0 > t_neg) && (x0 < t_pos);
  assign in_y0 = (y0 > t_neg) && (y0 < t_pos);
  assign in_x1 = (x1 > t_neg) && (x1 < t_pos);
  assign in_x2 = (x2 > t_neg) && (x2 < t_pos);

  assign all_down = (y0 > t_pos) && (y1 > t_pos) && (y2 > t_pos);
  assign all_up   = (y0 < t_neg) && (y1 < t_neg) && (y2 < t_neg);

  always_comb begin
    verdict.kind = KIND_PASS;
    verdict.key  = KEY_NONE;
    case (gesture_cnt)
      4'd0, 4'd2: begin
        verdict.kind = KIND_PASS;
      end
      4'd1: begin
        if (in_y0) begin
          if (x0 < t_neg) begin
            verdict.kind = KIND_KEY;
            verdict.key  = KEY_LEFT;
          end else if (x0 > t_pos) begin
            verdict.kind = KIND_KEY;
            verdict.key  = KEY_RIGHT;
          end else begin
            verdict.kind = KIND_MOUSE_TAP;
          end
        end
        if (in_x0) begin
          verdict.key = KEY_NONE;
          if (y0 < t_neg) begin
            verdict.kind = KIND_KEY;
            verdict.key  = KEY_UP;
          end else if (y0 > t_pos) begin
            verdict.kind = KIND_KEY;
            verdict.key  = KEY_DOWN;
          end else begin
            verdict.kind = KIND_TOUCH_TAP;
          end
        end
      end
      default: begin
        if (in_x0 && in_x1 && in_x2 && !all_down && !all_up) begin
          verdict.kind = KIND_KEY;
          verdict.key  = KEY_ESC;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/touch_swipe_gesture_classifier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_swipe_gesture_classifier_top
// Touch event stream in, classified key/tap/pass-through events out.
// ----------------------------------------------------------------------------
// One event word is taken per clock and its result word appears in the output
// register on the next clock. The finger slot tables and touch counters are
// updated at acceptance and the gesture decision is made in the same cycle
// from the slot registers, with the release position forwarded. in_chan.ready
// falls only while the output register holds a word that the sink does not
// take. The user must write the swipe threshold through cfg_we/cfg_data only
// while no word is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module touch_swipe_gesture_classifier_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data,
  tsgc_in_if.sink            in_chan,
  tsgc_out_if.source         out_chan
);
  import tsgc_pkg::*;

  logic [31:0]      press_r [FINGERS];
  logic [31:0]      last_r  [FINGERS];
  logic [CNT_W-1:0] active_r, active_nxt;
  logic [CNT_W-1:0] gesture_r, gesture_nxt;
  logic [15:0]      thr_r;

  logic        out_valid_r;
  logic [1:0]  out_type_r;
  logic [7:0]  key_code_r;
  logic [15:0] out_finger_r;
  logic [15:0] out_x_r;
  logic [15:0] out_y_r;

  logic             accept;
  logic             fid_ok;
  logic             do_move, do_press, do_release, last_release;
  logic [CNT_W-1:0] active_dec;
  logic [31:0]      pos;
  logic [31:0]      fwd0, fwd1, fwd2;
  disp_t            disp;
  verdict_t         verdict;
  logic [1:0]       kind;

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = !out_valid_r || out_chan.ready;

  assign fid_ok     = in_chan.finger_id < 16'(FINGERS);
  assign pos        = {in_chan.pos_y, in_chan.pos_x};
  assign do_move    = accept && fid_ok && (in_chan.mode == MODE_MOVE);
  assign do_press   = accept && fid_ok && (in_chan.mode == MODE_PRESS);
  assign do_release = accept && fid_ok && (in_chan.mode == MODE_RELEASE)
                      && (active_r != '0);
  assign active_dec   = active_r - 4'd1;
  assign last_release = do_release && (active_dec == '0);

  // release position forwarded into the decision
  assign fwd0 = (do_release && in_chan.finger_id == 16'd0) ? pos : last_r[0];
  assign fwd1 = (do_release && in_chan.finger_id == 16'd1) ? pos : last_r[1];
  assign fwd2 = (do_release && in_chan.finger_id == 16'd2) ? pos : last_r[2];

  assign disp.dx0 = $signed({1'b0, fwd0[15:0]}) - $signed({1'b0, press_r[0][15:0]});
  assign disp.dy0 = $signed({1'b0, fwd0[31:16]}) - $signed({1'b0, press_r[0][31:16]});
  assign disp.dx1 = $signed({1'b0, fwd1[15:0]}) - $signed({1'b0, press_r[1][15:0]});
  assign disp.dy1 = $signed({1'b0, fwd1[31:16]}) - $signed({1'b0, press_r[1][31:16]});
  assign disp.dx2 = $signed({1'b0, fwd2[15:0]}) - $signed({1'b0, press_r[2][15:0]});
  assign disp.dy2 = $signed({1'b0, fwd2[31:16]}) - $signed({1'b0, press_r[2][31:16]});

  tsgc_classify u_classify (
    .disp        (disp),
    .threshold   (thr_r),
    .gesture_cnt (gesture_r),
    .verdict     (verdict)
  );

  assign kind = last_release ? verdict.kind : KIND_PASS;

  always_comb begin
    active_nxt  = active_r;
    gesture_nxt = gesture_r;
    if (do_press) begin
      if (active_r != CNT_MAX) active_nxt = active_r + 4'd1;
      if (gesture_r != CNT_MAX) gesture_nxt = gesture_r + 4'd1;
    end
    if (do_release) begin
      active_nxt = active_dec;
    end
    if (last_release) begin
      gesture_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      gesture_r <= '0;
      thr_r     <= THR_RESET;
      for (int i = 0; i < FINGERS; i++) begin
        press_r[i] <= '0;
        last_r[i]  <= '0;
      end
    end else begin
      active_r  <= active_nxt;
      gesture_r <= gesture_nxt;
      if (cfg_we) thr_r <= cfg_data;
      for (int i = 0; i < FINGERS; i++) begin
        if (in_chan.finger_id == 16'(i)) begin
          if (do_press) press_r[i] <= pos;
          if (do_move || do_release) last_r[i] <= pos;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_type_r <= kind;
      if (kind == KIND_KEY) begin
        key_code_r   <= verdict.key;
        out_finger_r <= '0;
        out_x_r      <= '0;
        out_y_r      <= '0;
      end else begin
        key_code_r   <= KEY_NONE;
        out_finger_r <= (kind == KIND_PASS) ? in_chan.finger_id : 16'd1;
        out_x_r      <= in_chan.pos_x;
        out_y_r      <= in_chan.pos_y;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_type   = out_type_r;
  assign out_chan.key_code   = key_code_r;
  assign out_chan.out_finger = out_finger_r;
  assign out_chan.out_x      = out_x_r;
  assign out_chan.out_y      = out_y_r;

endmodule
`default_nettype wire

>>> src/tsgc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsgc_checker
// Port-level checks on the classifier top, attached by bind.
// ----------------------------------------------------------------------------
module tsgc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_type,
  input logic [7:0]  key_code,
  input logic [15:0] out_finger,
  input logic [15:0] out_x,
  input logic [15:0] out_y
);
  import tsgc_pkg::*;

  a_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_type == KIND_KEY) |->
      (out_finger == 16'd0 && out_x == 16'd0 && out_y == 16'd0 &&
       (key_code == KEY_LEFT || key_code == KEY_RIGHT || key_code == KEY_UP ||
        key_code == KEY_DOWN || key_code == KEY_ESC)))
    else $error("key word with bad fields");

  a_nokey_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_type != KIND_KEY) |-> (key_code == KEY_NONE))
    else $error("key code on a non-key word");

  a_tap_finger: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_type == KIND_TOUCH_TAP || out_type == KIND_MOUSE_TAP))
      |-> (out_finger == 16'd1))
    else $error("tap word without finger one");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word gave no result");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_type) && $stable(key_code) &&
       $stable(out_finger) && $stable(out_x) && $stable(out_y)))
    else $error("stalled result changed");

endmodule

bind touch_swipe_gesture_classifier_top tsgc_checker u_tsgc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_type   (out_chan.out_type),
  .key_code   (out_chan.key_code),
  .out_finger (out_chan.out_finger),
  .out_x      (out_chan.out_x),
  .out_y      (out_chan.out_y)
);
`default_nettype wire
